// ===== hdl/bhpq_pkg.sv =====
// Shared constants and controller/datapath interface types for the binary heap priority queue.
package bhpq_pkg;

    // Default sizing of the heap.
    localparam int HPQ_CAPACITY   = 1024;
    localparam int HPQ_DATA_WIDTH = 32;

    // Operation codes carried on the kind input.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_push;  // append a new item at the end of the heap
        logic start_pop;   // fetch the last element and shrink the heap
        logic take_last;   // latch the fetched last element as the moving value
        logic reject;      // flag the item as ignored
        logic rd_parent;   // read the parent of the current position
        logic rd_child;    // read both children of the current position
        logic push_step;   // one sift-up decision and write
        logic pop_step;    // one sift-down decision and write
        logic write_v;     // store the moving value at the current position
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic push_up;
        logic has_child;
        logic pop_down;
    } t_status;

endpackage

// ===== hdl/bhpq_ctrl.sv =====
// Sequencing state machine for the binary heap priority queue.
module bhpq_ctrl
    import bhpq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_kind,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy,
    output logic    o_valid
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_P_CHK  = 8'b0000_0010,
        ST_P_CMP  = 8'b0000_0100,
        ST_L_TAKE = 8'b0000_1000,
        ST_D_CHK  = 8'b0001_0000,
        ST_D_CMP  = 8'b0010_0000,
        ST_DONE   = 8'b0100_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_kind == KIND_PUSH) begin
                        if (i_status.full) begin
                            o_cmd.reject = 1'b1;
                            n_state      = ST_DONE;
                        end else begin
                            o_cmd.start_push = 1'b1;
                            n_state          = ST_P_CHK;
                        end
                    end else begin
                        if (i_status.empty) begin
                            o_cmd.reject = 1'b1;
                            n_state      = ST_DONE;
                        end else begin
                            o_cmd.start_pop = 1'b1;
                            n_state         = ST_L_TAKE;
                        end
                    end
                end
            end
            ST_P_CHK: begin
                if (i_status.at_root) begin
                    o_cmd.write_v = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = ST_P_CMP;
                end
            end
            ST_P_CMP: begin
                o_cmd.push_step = 1'b1;
                n_state         = i_status.push_up ? ST_P_CHK : ST_DONE;
            end
            ST_L_TAKE: begin
                o_cmd.take_last = 1'b1;
                n_state         = ST_D_CHK;
            end
            ST_D_CHK: begin
                if (i_status.has_child) begin
                    o_cmd.rd_child = 1'b1;
                    n_state        = ST_D_CMP;
                end else begin
                    o_cmd.write_v = 1'b1;
                    n_state       = ST_DONE;
                end
            end
            ST_D_CMP: begin
                o_cmd.pop_step = 1'b1;
                n_state        = i_status.pop_down ? ST_D_CHK : ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);

endmodule

// ===== hdl/bhpq_datapath.sv =====
// Heap memory, position and value registers, and comparators of the priority queue.
module bhpq_datapath
    import bhpq_pkg::*;
#(
    parameter int CAPACITY   = HPQ_CAPACITY,
    parameter int DATA_WIDTH = HPQ_DATA_WIDTH,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int PW = CW + 1,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [DATA_WIDTH-1:0] o_root_value,
    output logic [CW-1:0]         o_element_count,
    output logic                  o_rejected
);

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];

    logic [CW-1:0]         r_count;
    logic [PW-1:0]         r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [DATA_WIDTH-1:0] r_root;
    logic                  r_rej;
    logic                  r_order;
    logic [DATA_WIDTH-1:0] r_rd_a;
    logic [DATA_WIDTH-1:0] r_rd_b;

    logic [PW-1:0]         count_p;
    logic [PW-1:0]         parent_pos;
    logic [PW-1:0]         left_pos;
    logic [PW-1:0]         right_pos;
    logic                  has_right;
    logic                  right_better;
    logic [DATA_WIDTH-1:0] best_val;
    logic [PW-1:0]         best_pos;
    logic                  push_up;
    logic                  pop_down;

    logic                  rd_a_en;
    logic [PW-1:0]         rd_a_pos;
    logic                  wr_en;
    logic [PW-1:0]         wr_pos;
    logic [DATA_WIDTH-1:0] wr_data;

    // Strict heap order: a must sit above b.
    function automatic logic beats(input logic order_max,
                                   input logic [DATA_WIDTH-1:0] a,
                                   input logic [DATA_WIDTH-1:0] b);
        logic res;
        if (order_max) begin
            res = ($signed(a) > $signed(b));
        end else begin
            res = ($signed(a) < $signed(b));
        end
        return res;
    endfunction

    // Heap positions count from one; memory addresses from zero.
    function automatic logic [AW-1:0] to_addr(input logic [PW-1:0] pos);
        logic [PW-1:0] tmp;
        tmp = pos - PW'(1);
        return tmp[AW-1:0];
    endfunction

    // Neighbour positions of the current position.
    assign count_p    = PW'(r_count);
    assign parent_pos = r_pos >> 1;
    assign left_pos   = {r_pos[PW-2:0], 1'b0};
    assign right_pos  = {r_pos[PW-2:0], 1'b1};
    assign has_right  = (right_pos <= count_p);

    // Sift decisions.
    assign push_up      = beats(r_order, r_val, r_rd_a);
    assign right_better = has_right && beats(r_order, r_rd_b, r_rd_a);
    assign best_val     = right_better ? r_rd_b : r_rd_a;
    assign best_pos     = right_better ? right_pos : left_pos;
    assign pop_down     = beats(r_order, best_val, r_val);

    // Read port A address select.
    always_comb begin
        rd_a_en  = 1'b1;
        rd_a_pos = left_pos;
        if (i_cmd.start_pop) begin
            rd_a_pos = count_p;
        end else if (i_cmd.rd_parent) begin
            rd_a_pos = parent_pos;
        end else if (!i_cmd.rd_child) begin
            rd_a_en = 1'b0;
        end
    end

    // Write port select.
    always_comb begin
        wr_en   = 1'b0;
        wr_pos  = r_pos;
        wr_data = r_val;
        if (i_cmd.write_v) begin
            wr_en = 1'b1;
        end else if (i_cmd.push_step) begin
            wr_en   = 1'b1;
            wr_data = push_up ? r_rd_a : r_val;
        end else if (i_cmd.pop_step) begin
            wr_en   = 1'b1;
            wr_data = pop_down ? best_val : r_val;
        end
    end

    // Heap memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[to_addr(wr_pos)] <= wr_data;
        end
        if (rd_a_en) begin
            r_rd_a <= r_mem[to_addr(rd_a_pos)];
        end
        if (i_cmd.rd_child) begin
            r_rd_b <= r_mem[to_addr(right_pos)];
        end
    end

    // Control registers: count, reject flag and heap order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rej   <= 1'b0;
            r_order <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_order <= i_cfg_wr_data;
            end
            if (i_cmd.start_push) begin
                r_count <= r_count + CW'(1);
                r_rej   <= 1'b0;
            end else if (i_cmd.start_pop) begin
                r_count <= r_count - CW'(1);
                r_rej   <= 1'b0;
            end else if (i_cmd.reject) begin
                r_rej <= 1'b1;
            end
        end
    end

    // Moving value, current position and a copy of the root.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_push) begin
            r_pos <= count_p + PW'(1);
            r_val <= i_value;
        end else if (i_cmd.start_pop) begin
            r_pos <= PW'(1);
        end else if (i_cmd.take_last) begin
            r_val <= r_rd_a;
        end else if (i_cmd.push_step && push_up) begin
            r_pos <= parent_pos;
        end else if (i_cmd.pop_step && pop_down) begin
            r_pos <= best_pos;
        end
        if (wr_en && (wr_pos == PW'(1))) begin
            r_root <= wr_data;
        end
    end

    // Status to the controller.
    assign o_status.full      = (r_count == CW'(CAPACITY));
    assign o_status.empty     = (r_count == '0);
    assign o_status.at_root   = (r_pos == PW'(1));
    assign o_status.push_up   = push_up;
    assign o_status.has_child = (left_pos <= count_p);
    assign o_status.pop_down  = pop_down;

    // Result fields.
    assign o_root_value    = (r_count != '0) ? r_root : '0;
    assign o_element_count = r_count;
    assign o_rejected      = r_rej;

endmodule

// ===== hdl/binary_heap_priority_queue.sv =====
// Top level of the binary heap priority queue: controller and datapath.
//
// Usage: raise start with i_kind and i_value while busy is low; the item is
// taken at that clock edge. A push (kind 0) inserts i_value, a pop (kind 1)
// removes the root. Each item gives one result, shown for a single cycle
// with o_valid high: the root after the operation (0 when empty), the
// element count, and o_rejected when a push on a full heap or a pop on an
// empty heap was ignored. The receiver cannot stall; it must take the
// result in the cycle o_valid is high.
// The heap lives in one memory with one write and two read ports, and each
// level of sift-up or sift-down is a read, then a compare and write. A
// rejected item goes straight to the result. busy stays high through the
// result cycle, so the next item is taken only after it; one item is
// handled at a time.
// i_cfg_wr_en with i_cfg_wr_data selects max-heap (1) or min-heap (0)
// order; write it only while the heap is idle.
// Reset empties the heap and selects min-heap order; memory contents are
// not cleared, since values read from unstored positions are never used.
module binary_heap_priority_queue
    import bhpq_pkg::*;
#(
    parameter int CAPACITY   = HPQ_CAPACITY,
    parameter int DATA_WIDTH = HPQ_DATA_WIDTH,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_kind,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_root_value,
    output logic [CW-1:0]         o_element_count,
    output logic                  o_rejected
);

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    bhpq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    // Storage and comparison.
    bhpq_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_value         (i_value),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_root_value    (o_root_value),
        .o_element_count (o_element_count),
        .o_rejected      (o_rejected)
    );

endmodule
